// ----- design/smpf_pkg.sv -----
package smpf_pkg;

  // Command codes carried in s_tuser
  localparam logic [1:0] CMD_EVENT = 2'd0;
  localparam logic [1:0] CMD_READY = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;

  // Operation kinds passed from front to back
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_RTS   = 2'd3;

  // UART register details
  localparam logic [2:0] REG_MCR  = 3'd4;
  localparam int         MCR_RTS  = 1;
  localparam logic [7:0] ID_BYTE  = 8'h4D;  // 'M'

  // Packet framing
  localparam logic [7:0] HDR_BYTE = 8'h40;
  localparam logic [7:0] X_HIGH   = 8'h03;
  localparam logic [7:0] Y_HIGH   = 8'h0C;

  // One classified operation
  typedef struct packed {
    logic [1:0] kind;
    logic       idle;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } op_t;

endpackage

// ----- design/smpf_ram.sv -----
module smpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/smpf_front.sv -----
module smpf_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 q_valid,
  input  logic                 q_pop,
  output smpf_pkg::op_t        q_op
);
  import smpf_pkg::*;

  logic [1:0] buttons;
  logic [6:0] dx;
  logic [6:0] dy;
  logic [2:0] reg_index;
  logic [7:0] reg_value;
  logic       uart_idle;
  op_t        op_new;
  op_t        q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;

  // Unpack the transaction
  assign buttons   = s_tdata[1:0];
  assign dx        = s_tdata[8:2];
  assign dy        = s_tdata[15:9];
  assign reg_index = s_tdata[18:16];
  assign reg_value = s_tdata[26:19];
  assign uart_idle = s_tdata[27];

  // Classify and pre-build the packet bytes
  always_comb begin
    op_new.idle  = uart_idle;
    op_new.byte0 = HDR_BYTE | {2'b00, buttons, 4'b0000}
                 | (dx[6] ? X_HIGH : 8'h00) | (dy[6] ? Y_HIGH : 8'h00);
    op_new.byte1 = {2'b00, dx[5:0]};
    op_new.byte2 = {2'b00, dy[5:0]};
    case (s_tuser)
      CMD_EVENT: op_new.kind = OP_EVENT;
      CMD_READY: op_new.kind = OP_TICK;
      CMD_WRITE: op_new.kind = (reg_index == REG_MCR && reg_value[MCR_RTS]) ? OP_RTS : OP_NOP;
      default:   op_new.kind = OP_NOP;
    endcase
    if (op_new.kind == OP_RTS) begin
      op_new.byte0 = ID_BYTE;
    end
  end

  // Two-entry queue towards the back end
  assign s_tready = (q_cnt != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (q_cnt != 2'd0);
  assign q_op     = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= op_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, q_pop && q_valid})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

// ----- design/smpf_back.sv -----
module smpf_back #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  smpf_pkg::op_t        q_op,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata
);
  import smpf_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int LW = (CW > 8) ? CW : 8;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]    state;
  logic [1:0]    step;
  op_t           op;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          sent;
  logic          acc;
  logic [7:0]    tx_byte;
  logic          rd_pend;
  logic [7:0]    rd_data;

  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;
  logic [AW-1:0] head_inc;
  logic          full;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    cur_byte;
  logic          out_free;
  logic          take_op;
  logic [7:0]    res_byte;
  logic [LW-1:0] cnt_ext;

  // Ring pointers
  assign tail_sum = {1'b0, (CW)'(head)} + {1'b0, count};
  assign tail     = (tail_sum >= (CW + 1)'(FIFO_DEPTH))
                  ? AW'(tail_sum - (CW + 1)'(FIFO_DEPTH)) : AW'(tail_sum);
  assign head_inc = (head == AW'(FIFO_DEPTH - 1)) ? '0 : head + AW'(1);
  assign full     = (count >= CW'(FIFO_DEPTH));

  always_comb begin
    case (step)
      2'd0:    cur_byte = op.byte0;
      2'd1:    cur_byte = op.byte1;
      default: cur_byte = op.byte2;
    endcase
  end

  // Store write for the current step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail;
    ram_wdata = cur_byte;
    if (state == S_RUN) begin
      case (op.kind)
        OP_EVENT: ram_we = !full;
        OP_RTS: begin
          ram_we    = !op.idle;
          ram_waddr = head;
          ram_wdata = ID_BYTE;
        end
        default: ram_we = 1'b0;
      endcase
    end
  end

  smpf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head),
    .rdata (rd_data)
  );

  // Handshake with queue and output register
  assign out_free = !m_tvalid || m_tready;
  assign take_op  = q_valid && (state == S_IDLE || (state == S_FIN && out_free));
  assign q_pop    = take_op;
  assign res_byte = rd_pend ? rd_data : tx_byte;
  assign cnt_ext  = LW'(count);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= 2'd0;
      head    <= '0;
      count   <= '0;
      sent    <= 1'b0;
      acc     <= 1'b1;
      rd_pend <= 1'b0;
      tx_byte <= 8'h00;
    end else begin
      rd_pend <= 1'b0;
      if (rd_pend) begin
        tx_byte <= rd_data;
      end
      case (state)
        S_RUN: begin
          case (op.kind)
            OP_EVENT: begin
              if (full) begin
                acc   <= 1'b0;
                state <= S_FIN;
              end else begin
                if (step == 2'd0 && op.idle) begin
                  // pushed and popped at once: level unchanged
                  sent <= 1'b1;
                  head <= head_inc;
                  if (count == '0) begin
                    tx_byte <= op.byte0;
                  end else begin
                    rd_pend <= 1'b1;
                  end
                end else begin
                  count <= count + CW'(1);
                end
                if (step == 2'd2) begin
                  state <= S_FIN;
                end
                step <= step + 2'd1;
              end
            end
            OP_TICK: begin
              if (count != '0) begin
                sent    <= 1'b1;
                rd_pend <= 1'b1;
                head    <= head_inc;
                count   <= count - CW'(1);
              end
              state <= S_FIN;
            end
            OP_RTS: begin
              if (op.idle) begin
                sent    <= 1'b1;
                tx_byte <= ID_BYTE;
                head    <= head_inc;
                count   <= '0;
              end else begin
                count <= CW'(1);
              end
              state <= S_FIN;
            end
            default: state <= S_FIN;
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (take_op) begin
        state   <= S_RUN;
        step    <= 2'd0;
        sent    <= 1'b0;
        acc     <= 1'b1;
        tx_byte <= 8'h00;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_op) begin
      op <= q_op;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      m_tdata <= {6'b0, cnt_ext[7:0], acc, res_byte, sent};
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(FIFO_DEPTH))
    else $error("fifo count above depth");

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= AW'(FIFO_DEPTH - 1))
    else $error("fifo head out of range");

  a_pend_sent: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> sent)
    else $error("store read pending without a send");

  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'h00)
    else $error("byte shown without a send");
`endif

endmodule

// ----- design/serial_mouse_packet_fifo.sv -----
// m_tvalid rises once the back-end sequencer has finished an accepted event, ready tick
// or register write; an event cut short by a full FIFO finishes sooner.
// The back end works on one item at a time and takes the next as the last one's result
// is registered, writing one packet byte per cycle through the single store write port.
// Reset: rst clears pointers, count, queue and handshake state; store contents are
// not cleared and no clearing pass is run.
module serial_mouse_packet_fifo #(
  parameter int FIFO_DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // buttons[1:0], dx[8:2], dy[15:9], reg_index[18:16], reg_value[26:19],
  // uart_idle[27], zero[31:28]
  input  logic [31:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // tx_valid[0], tx_byte[8:1], accepted[9], fifo_level[17:10], zero[23:18]
  output logic [23:0] m_tdata
);
  import smpf_pkg::*;

  logic q_valid;
  logic q_pop;
  op_t  q_op;

  smpf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op)
  );

  smpf_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_op     (q_op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
